### hdl/ncassign_pkg.sv
// ----------------------------------------------------------------------------
// ncassign_pkg: shared types and constants
// Field widths, item and status structs, opcode and sequencer encodings for
// the nearest centroid assignment block.
// ----------------------------------------------------------------------------
package ncassign_pkg;

    localparam int NUM_CLUSTERS = 8;
    localparam int CID_BITS     = $clog2(NUM_CLUSTERS);
    localparam int NUM_DIMS     = 1024;
    localparam int DIM_BITS     = $clog2(NUM_DIMS);
    localparam int VALUE_BITS   = 16;
    localparam int SQ_BITS      = 2 * VALUE_BITS + 1;
    localparam int SUM_BITS     = 48;
    localparam int CCOUNT_BITS  = 4;
    localparam int ADDR_BITS    = CID_BITS + DIM_BITS;
    localparam int STORE_DEPTH  = NUM_CLUSTERS * NUM_DIMS;
    localparam logic [CCOUNT_BITS-1:0] CCOUNT_RESET = CCOUNT_BITS'(NUM_CLUSTERS);

    typedef enum logic [0:0] {
        OPC_LOAD   = 1'b0,
        OPC_SAMPLE = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                        opcode;
        logic [CID_BITS-1:0]            centroid_index;
        logic [DIM_BITS-1:0]            dim_index;
        logic signed [VALUE_BITS-1:0]   value;
        logic                           is_last;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_stat;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_DRAIN = 2'd2
    } t_back_state;

endpackage

### hdl/nearest_centroid_assign_top.sv
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top: nearest centroid assignment
// A load beat is written to the centroid memory as it leaves the queue head;
// a sample beat holds the back end through its centroid memory reads, one per
// cycle and one per active centroid, then a drain; the result strobe comes in
// the cycle after the final beat's last accumulation. No new beat is taken
// until a sample beat has drained; load beats go one per cycle otherwise.
// Reset empties the queue, clears all sums and sets cluster_count to 8; the
// centroid memory is not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_opcode,
    input  logic [ncassign_pkg::CID_BITS-1:0]     i_centroid_index,
    input  logic [ncassign_pkg::DIM_BITS-1:0]     i_dim_index,
    input  logic signed [ncassign_pkg::VALUE_BITS-1:0] i_value,
    input  logic                                  i_is_last,
    input  logic                                  i_cfg_we,
    input  logic [ncassign_pkg::CCOUNT_BITS-1:0]  i_cfg_data,
    output logic                                  o_done,
    output logic [ncassign_pkg::CID_BITS-1:0]     o_nearest_idx,
    output logic [ncassign_pkg::SUM_BITS-1:0]     o_best_dist
);
    import ncassign_pkg::*;

    logic [CCOUNT_BITS-1:0] r_cluster_count;
    logic [CID_BITS-1:0]    w_last_idx;
    t_item                  w_in_item;
    t_item                  w_q_item;
    logic                   w_q_valid;
    logic                   w_pop;
    t_queue_stat            w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_cluster_count <= i_cfg_data;
        end
    end

    // zero acts as one, above the table size acts as full table
    always_comb begin
        priority if (r_cluster_count == '0) begin
            w_last_idx = '0;
        end else if (r_cluster_count > CCOUNT_BITS'(NUM_CLUSTERS)) begin
            w_last_idx = CID_BITS'(NUM_CLUSTERS - 1);
        end else begin
            w_last_idx = CID_BITS'(r_cluster_count - 1'b1);
        end
    end

    assign w_in_item.opcode         = t_opcode'(i_opcode);
    assign w_in_item.centroid_index = i_centroid_index;
    assign w_in_item.dim_index      = i_dim_index;
    assign w_in_item.value          = i_value;
    assign w_in_item.is_last        = i_is_last;

    ncassign_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (w_in_item),
        .o_busy       (busy),
        .o_item       (w_q_item),
        .o_item_valid (w_q_valid),
        .i_pop        (w_pop),
        .o_stat       (w_q_stat)
    );

    ncassign_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_q_item),
        .i_item_valid  (w_q_valid),
        .o_pop         (w_pop),
        .i_last_idx    (w_last_idx),
        .o_done        (o_done),
        .o_nearest_idx (o_nearest_idx),
        .o_best_dist   (o_best_dist)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !w_q_stat.empty)
        else $error("accepted beat missing from queue");

    a_full_busy: assert property (@(posedge i_clk)
        w_q_stat.full |-> busy)
        else $error("queue full but not busy");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

endmodule

### hdl/ncassign_ram.sv
// ----------------------------------------------------------------------------
// ncassign_ram: generic simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ncassign_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/ncassign_front.sv
// ----------------------------------------------------------------------------
// ncassign_front: input acceptance and item queue
// Takes command beats while the queue has room and hands them to the back
// end in arrival order.
// ----------------------------------------------------------------------------
module ncassign_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  ncassign_pkg::t_item       i_item,
    output logic                      o_busy,
    output ncassign_pkg::t_item       o_item,
    output logic                      o_item_valid,
    input  logic                      i_pop,
    output ncassign_pkg::t_queue_stat o_stat
);
    import ncassign_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    t_item               r_queue [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, n_wptr;
    logic [PTR_BITS-1:0] r_rptr, n_rptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                w_push;
    logic                w_pop;
    logic                w_full;
    logic                w_empty;

    assign w_full  = (r_count == CNT_FULL);
    assign w_empty = (r_count == '0);
    assign o_busy  = w_full || !i_rst_n;
    assign w_push  = i_start && !o_busy;
    assign w_pop   = i_pop && !w_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (w_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        priority if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wptr] <= i_item;
        end
    end

    assign o_item       = r_queue[r_rptr];
    assign o_item_valid = !w_empty;
    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;

endmodule

### hdl/ncassign_back.sv
// ----------------------------------------------------------------------------
// ncassign_back: centroid store and distance engine
// Writes load beats into the centroid memory; for a sample beat reads one
// centroid per cycle, squares the difference and accumulates, tracking the
// nearest centroid and reporting it on the final beat of a vector.
// ----------------------------------------------------------------------------
module ncassign_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  ncassign_pkg::t_item                    i_item,
    input  logic                                   i_item_valid,
    output logic                                   o_pop,
    input  logic [ncassign_pkg::CID_BITS-1:0]      i_last_idx,
    output logic                                   o_done,
    output logic [ncassign_pkg::CID_BITS-1:0]      o_nearest_idx,
    output logic [ncassign_pkg::SUM_BITS-1:0]      o_best_dist
);
    import ncassign_pkg::*;

    t_back_state                  r_state, n_state;
    t_item                        r_cur;
    logic [CID_BITS-1:0]          r_idx, n_idx;
    logic                         r_v1;
    logic [CID_BITS-1:0]          r_i1;
    logic                         r_v2;
    logic [CID_BITS-1:0]          r_i2;
    logic [SQ_BITS-1:0]           r_sq;
    logic [SUM_BITS-1:0]          r_sums [NUM_CLUSTERS];
    logic [SUM_BITS-1:0]          r_best_sum;
    logic [CID_BITS-1:0]          r_best_id;
    logic                         r_done;

    logic                         w_we;
    logic                         w_re;
    logic [ADDR_BITS-1:0]         w_waddr;
    logic [ADDR_BITS-1:0]         w_raddr;
    logic [VALUE_BITS-1:0]        w_rdata;
    logic signed [VALUE_BITS:0]   w_diff;
    logic signed [2*VALUE_BITS+1:0] w_prod;
    logic [SUM_BITS:0]            w_sum;
    logic [SUM_BITS-1:0]          w_sat;
    logic                         w_final;
    logic                         w_clear;
    logic                         w_take;

    ncassign_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_item.value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_item_valid && i_item.opcode == OPC_SAMPLE) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (r_idx == i_last_idx) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (w_final) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_pop = 1'b0;
        w_we  = 1'b0;
        w_re  = 1'b0;
        n_idx = r_idx;
        unique case (r_state)
            BK_IDLE: begin
                o_pop = i_item_valid;
                w_we  = i_item_valid && i_item.opcode == OPC_LOAD;
                n_idx = '0;
            end
            BK_READ: begin
                w_re  = 1'b1;
                n_idx = r_idx + 1'b1;
            end
            BK_DRAIN: begin
                n_idx = r_idx;
            end
            default: n_idx = '0;
        endcase
    end

    assign w_waddr = {i_item.centroid_index, i_item.dim_index};
    assign w_raddr = {r_idx, r_cur.dim_index};

    // square stage
    assign w_diff = {r_cur.value[VALUE_BITS-1], r_cur.value}
                  - $signed({w_rdata[VALUE_BITS-1], w_rdata});
    assign w_prod = w_diff * w_diff;

    // accumulate stage
    assign w_sum   = {1'b0, r_sums[r_i2]} + (SUM_BITS+1)'(r_sq);
    assign w_sat   = w_sum[SUM_BITS] ? '1 : w_sum[SUM_BITS-1:0];
    assign w_final = r_v2 && (r_i2 == i_last_idx);
    assign w_clear = w_final && r_cur.is_last;
    assign w_take  = (r_i2 == '0) || (w_sat < r_best_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done  <= 1'b0;
            for (int k = 0; k < NUM_CLUSTERS; k++) begin
                r_sums[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_v1    <= w_re;
            r_v2    <= r_v1;
            r_done  <= w_clear;
            if (w_clear) begin
                for (int k = 0; k < NUM_CLUSTERS; k++) begin
                    r_sums[k] <= '0;
                end
            end else if (r_v2) begin
                r_sums[r_i2] <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_item;
        end
        r_i1 <= r_idx;
        r_i2 <= r_i1;
        r_sq <= w_prod[SQ_BITS-1:0];
        if (r_v2 && w_take) begin
            r_best_sum <= w_sat;
            r_best_id  <= r_i2;
        end
    end

    assign o_done        = r_done;
    assign o_nearest_idx = r_best_id;
    assign o_best_dist   = r_best_sum;

endmodule

### tb/nearest_centroid_assign_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top_tb: self-checking bench for centroid assignment
// Loads a centroid table, streams sample vectors under several cluster counts
// and sender idle patterns, and scores every result strobe against a local
// squared-distance accumulator that tracks the table, the sums and the count.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top_tb;
    import ncassign_pkg::*;

    localparam int  CYCLE_LIMIT  = 2_000_000;
    localparam int  SETTLE       = 80;
    localparam int  MAX_GAP      = 40;
    localparam int  LONG_BEATS   = 100;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef struct {
        logic [CID_BITS-1:0] nearest_idx;
        logic [SUM_BITS-1:0] best_dist;
    } t_nearest;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic                          i_opcode;
    logic [CID_BITS-1:0]           i_centroid_index;
    logic [DIM_BITS-1:0]           i_dim_index;
    logic signed [VALUE_BITS-1:0]  i_value;
    logic                          i_is_last;
    logic                          i_cfg_we;
    logic [CCOUNT_BITS-1:0]        i_cfg_data;
    logic                          o_done;
    logic [CID_BITS-1:0]           o_nearest_idx;
    logic [SUM_BITS-1:0]           o_best_dist;

    logic signed [VALUE_BITS-1:0]  centroid_mem [NUM_CLUSTERS][NUM_DIMS];
    bit                            col_loaded [NUM_CLUSTERS][NUM_DIMS];
    bit                            dim_ready [NUM_DIMS];
    int                            ready_dims [$];
    logic [SUM_BITS-1:0]           dist_sums [NUM_CLUSTERS];
    logic [CCOUNT_BITS-1:0]        cluster_count;
    t_nearest                      nearest_q [$];
    int                            mismatches;
    int                            idle_pct;
    int unsigned                   cycle_count;

    nearest_centroid_assign_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_centroid_index (i_centroid_index),
        .i_dim_index      (i_dim_index),
        .i_value          (i_value),
        .i_is_last        (i_is_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_nearest_idx    (o_nearest_idx),
        .o_best_dist      (o_best_dist)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_nearest exp_r;
        if (i_rst_n && o_done === 1'b1) begin
            if (nearest_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: nearest_idx %0d best_dist %0d",
                             o_nearest_idx, o_best_dist);
                mismatches = mismatches + 1;
            end else begin
                exp_r = nearest_q.pop_front();
                if (o_nearest_idx !== exp_r.nearest_idx ||
                    o_best_dist !== exp_r.best_dist) begin
                    if (mismatches < 10)
                        $display("mismatch: nearest_idx exp %0d got %0d, best_dist exp %0d got %0d",
                                 exp_r.nearest_idx, o_nearest_idx,
                                 exp_r.best_dist, o_best_dist);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    function automatic int active_clusters();
        if (cluster_count == 0)
            return 1;
        if (cluster_count > NUM_CLUSTERS)
            return NUM_CLUSTERS;
        return int'(cluster_count);
    endfunction

    // table update, distance accumulation and nearest pick for one beat
    task automatic assign_nearest(input t_opcode op, input logic [CID_BITS-1:0] ci,
                                  input logic [DIM_BITS-1:0] di,
                                  input logic signed [VALUE_BITS-1:0] val,
                                  input logic last);
        int                n;
        bit                full;
        longint            diff;
        longint unsigned   acc;
        t_nearest          res;
        if (op == OPC_LOAD) begin
            centroid_mem[ci][di] = val;
            col_loaded[ci][di] = 1'b1;
            full = 1'b1;
            for (int c = 0; c < NUM_CLUSTERS; c++)
                if (!col_loaded[c][di])
                    full = 1'b0;
            if (full && !dim_ready[di]) begin
                dim_ready[di] = 1'b1;
                ready_dims.push_back(int'(di));
            end
            return;
        end
        n = active_clusters();
        for (int c = 0; c < n; c++) begin
            diff = longint'(val) - longint'(centroid_mem[c][di]);
            acc = longint'(dist_sums[c]) + diff * diff;
            dist_sums[c] = (acc > longint'(SUM_MAX)) ? SUM_MAX : acc[SUM_BITS-1:0];
        end
        if (!last)
            return;
        res.nearest_idx = '0;
        res.best_dist = dist_sums[0];
        for (int c = 1; c < n; c++) begin
            if (dist_sums[c] < res.best_dist) begin
                res.best_dist = dist_sums[c];
                res.nearest_idx = CID_BITS'(c);
            end
        end
        for (int c = 0; c < NUM_CLUSTERS; c++)
            dist_sums[c] = '0;
        nearest_q.push_back(res);
    endtask

    // one beat; start stays high on return so a following beat can go back to back
    task automatic send_beat(input t_opcode op, input logic [CID_BITS-1:0] ci,
                             input logic [DIM_BITS-1:0] di,
                             input logic signed [VALUE_BITS-1:0] val,
                             input logic last);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_opcode         <= op;
        i_centroid_index <= ci;
        i_dim_index      <= di;
        i_value          <= val;
        i_is_last        <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        assign_nearest(op, ci, di, val, last);
    endtask

    task automatic wait_block_idle();
        start <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cluster_count(input logic [CCOUNT_BITS-1:0] count);
        wait_block_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cluster_count = count;
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len, input bit close);
        int di;
        for (int k = 0; k < len; k++) begin
            di = ready_dims[$urandom_range(ready_dims.size() - 1)];
            send_beat(OPC_SAMPLE, CID_BITS'($urandom), DIM_BITS'(di), pick_value(),
                      close && (k == len - 1));
        end
    endtask

    task automatic test_table_load();
        logic signed [VALUE_BITS-1:0] dim0_vals [NUM_CLUSTERS];
        int                           dims [4];
        dim0_vals = '{16'sh7fff, 16'sh0000, 16'sh8000, 16'sh0000,
                      16'shffff, 16'sh0001, 16'sh4000, 16'shc000};
        dims = '{0, 1023, 341, 682};
        idle_pct = 0;
        foreach (dims[j])
            for (int c = 0; c < NUM_CLUSTERS; c++)
                send_beat(OPC_LOAD, CID_BITS'(c), DIM_BITS'(dims[j]),
                          (j == 0) ? dim0_vals[c] : pick_value(), 1'b0);
    endtask

    task automatic test_directed_cases();
        // most negative sample against the full-scale centroids
        send_beat(OPC_SAMPLE, '0, 10'd0, 16'sh8000, 1'b1);
        send_beat(OPC_SAMPLE, '1, 10'd0, 16'sh7fff, 1'b0);
        send_beat(OPC_SAMPLE, '0, 10'd1023, 16'sh7fff, 1'b0);
        send_beat(OPC_SAMPLE, '0, 10'd341, 16'sh8000, 1'b0);
        send_beat(OPC_SAMPLE, '0, 10'd682, 16'sh7fff, 1'b1);
        // tie between two equal centroids goes to the lower index
        send_beat(OPC_SAMPLE, '0, 10'd0, 16'sh0000, 1'b1);
        // load marked last inside a vector
        send_beat(OPC_SAMPLE, '0, 10'd1023, 16'sh1234, 1'b0);
        send_beat(OPC_LOAD, 3'd2, 10'd200, 16'sh5555, 1'b1);
        send_beat(OPC_SAMPLE, '0, 10'd341, 16'shedcb, 1'b1);
    endtask

    task automatic test_cluster_count_range();
        write_cluster_count(4'd0);
        send_vector(3, 1'b1);
        write_cluster_count(4'd15);
        send_vector(3, 1'b1);
        write_cluster_count(4'd9);
        send_vector(2, 1'b1);
        write_cluster_count(4'd1);
        send_vector(2, 1'b1);
        write_cluster_count(4'd8);
        send_vector(1, 1'b1);
    endtask

    // long vector of full-scale differences against two close centroids
    task automatic test_long_vector();
        idle_pct = 0;
        send_beat(OPC_LOAD, 3'd0, 10'd341, 16'sh8000, 1'b0);
        send_beat(OPC_LOAD, 3'd1, 10'd341, 16'sh8001, 1'b0);
        write_cluster_count(4'd2);
        for (int k = 0; k < LONG_BEATS; k++)
            send_beat(OPC_SAMPLE, '0, 10'd341, 16'sh7fff, k == LONG_BEATS - 1);
    endtask

    task automatic run_random_phase(input int pct, input int beats);
        int count;
        int r;
        int len;
        int base;
        int step;
        int di;
        idle_pct = pct;
        count = 0;
        while (count < beats) begin
            r = $urandom_range(99);
            if (r < 70) begin
                len = ($urandom_range(15) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
                send_vector(len, 1'b1);
                count += len;
            end else if (r < 80) begin
                di = $urandom_range(NUM_DIMS - 1);
                base = $urandom_range(NUM_CLUSTERS - 1);
                step = 2 * $urandom_range(3) + 1;
                for (int k = 0; k < NUM_CLUSTERS; k++)
                    send_beat(OPC_LOAD, CID_BITS'((base + k * step) % NUM_CLUSTERS),
                              DIM_BITS'(di), pick_value(), 1'($urandom));
                count += NUM_CLUSTERS;
            end else if (r < 92) begin
                send_beat(OPC_LOAD, CID_BITS'($urandom), DIM_BITS'($urandom),
                          pick_value(), 1'($urandom));
                count += 1;
            end else begin
                // broken vector: samples without a close, then a stray load marked last
                len = $urandom_range(4, 1);
                send_vector(len, 1'b0);
                send_beat(OPC_LOAD, CID_BITS'($urandom), DIM_BITS'($urandom),
                          pick_value(), 1'b1);
                count += len + 1;
            end
        end
    endtask

    task automatic test_random_traffic();
        write_cluster_count(4'd8);
        run_random_phase(0, 280);
        write_cluster_count(4'd1);
        run_random_phase(87, 280);
        write_cluster_count(4'd15);
        run_random_phase(14, 280);
        write_cluster_count(CCOUNT_BITS'($urandom_range(7, 2)));
        run_random_phase(87, 280);
    endtask

    initial begin
        cycle_count      = 0;
        mismatches       = 0;
        idle_pct         = 0;
        cluster_count    = CCOUNT_RESET;
        for (int c = 0; c < NUM_CLUSTERS; c++)
            dist_sums[c] = '0;
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_opcode         <= OPC_LOAD;
        i_centroid_index <= '0;
        i_dim_index      <= '0;
        i_value          <= '0;
        i_is_last        <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_directed_cases();
        test_cluster_count_range();
        test_long_vector();
        test_random_traffic();

        wait_block_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
